/* hw/rtl/epg_pkg.sv */
// Shared types and constants for the ellipse point generator.
package epg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 32;
  localparam int COMP_W       = 16;
  localparam int REG_W        = 48;
  localparam int OUT_W        = 18;
  localparam int AXES         = 3;
  localparam int CFG_ADDR_W   = 2;

  // Gain-compensated start value of the rotation, Q2.30.
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860
  };

  localparam logic [CFG_ADDR_W-1:0] REG_MAJOR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MINOR  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER = 2'd2;

  localparam logic [REG_W-1:0] MAJOR_RESET  = 48'd4096;
  localparam logic [REG_W-1:0] MINOR_RESET  = 48'd268435456;
  localparam logic [REG_W-1:0] CENTER_RESET = 48'd0;

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quadrant_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    quadrant_t                  quad;
  } cordic_word_t;

endpackage

/* hw/rtl/ellipse_point_generator_core.sv */
// Ellipse point generator: a row of 16 CORDIC cells followed by rounding and vector math.
// Each accepted word passes through the 16 cells and then 3 output stages to its result word.
// Throughput: one word per cycle while out_ready holds; then every cell and stage passes a word on in each cycle.
// Each stage holds its word while the next one is full, so bubbles collapse under stalls.
// Reset (rst, synchronous) empties the pipeline and loads the default axis and center vectors.
module ellipse_point_generator_core #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [epg_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [epg_pkg::REG_W-1:0]             cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [15:0]                           turn_fraction,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [epg_pkg::OUT_W-1:0]      point_x,
  output logic signed [epg_pkg::OUT_W-1:0]      point_y,
  output logic signed [epg_pkg::OUT_W-1:0]      point_z,
  output logic signed [epg_pkg::OUT_W-1:0]      tangent_x,
  output logic signed [epg_pkg::OUT_W-1:0]      tangent_y,
  output logic signed [epg_pkg::OUT_W-1:0]      tangent_z
);
  import epg_pkg::*;

  localparam int KEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
  localparam logic [CORDIC_W-1:0] PHASE_MASK = ~((32'd1 << (CORDIC_W - KEEP)) - 32'd1);

  logic [REG_W-1:0] major_axis_vector;
  logic [REG_W-1:0] minor_axis_vector;
  logic [REG_W-1:0] center_vector;

  logic [CORDIC_W-1:0] phase;
  cordic_word_t        chain_word  [CORDIC_STEPS+1];
  logic                chain_valid [CORDIC_STEPS+1];
  logic                chain_ready [CORDIC_STEPS+1];

  logic signed [OUT_W-1:0] point   [AXES];
  logic signed [OUT_W-1:0] tangent [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      major_axis_vector <= MAJOR_RESET;
      minor_axis_vector <= MINOR_RESET;
      center_vector     <= CENTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAJOR:  major_axis_vector <= cfg_wdata;
        REG_MINOR:  minor_axis_vector <= cfg_wdata;
        REG_CENTER: center_vector     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The top two phase bits pick the quadrant; the cells rotate the rest.
  always_comb begin
    phase              = {turn_fraction, 16'd0} & PHASE_MASK;
    chain_word[0].x    = CORDIC_X0;
    chain_word[0].y    = '0;
    chain_word[0].z    = $signed({2'b00, phase[CORDIC_W-3:0]});
    chain_word[0].quad = quadrant_t'(phase[CORDIC_W-1:CORDIC_W-2]);
  end

  assign chain_valid[0] = in_valid;
  assign in_ready       = chain_ready[0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    epg_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (chain_valid[i]),
      .up_ready   (chain_ready[i]),
      .up_word    (chain_word[i]),
      .valid      (chain_valid[i+1]),
      .down_ready (chain_ready[i+1]),
      .word       (chain_word[i+1])
    );
  end

  epg_combine #(
    .COORD_BITS (COORD_BITS)
  ) u_combine (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (chain_valid[CORDIC_STEPS]),
    .in_ready          (chain_ready[CORDIC_STEPS]),
    .in_word           (chain_word[CORDIC_STEPS]),
    .major_axis_vector (major_axis_vector),
    .minor_axis_vector (minor_axis_vector),
    .center_vector     (center_vector),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .point             (point),
    .tangent           (tangent)
  );

  assign point_x   = point[0];
  assign point_y   = point[1];
  assign point_z   = point[2];
  assign tangent_x = tangent[0];
  assign tangent_y = tangent[1];
  assign tangent_z = tangent[2];

endmodule

/* hw/rtl/epg_cordic_cell.sv */
// One CORDIC rotation step with its own pipeline register and handshake.
module epg_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  epg_pkg::cordic_word_t up_word,
  output logic                  valid,
  input  logic                  down_ready,
  output epg_pkg::cordic_word_t word
);
  import epg_pkg::*;

  localparam logic [3:0] STEP_IDX = 4'(STEP);

  cordic_word_t word_next;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;

  assign up_ready = !valid || down_ready;

  always_comb begin
    dx        = up_word.y >>> STEP;
    dy        = up_word.x >>> STEP;
    word_next = up_word;
    if (!up_word.z[CORDIC_W-1]) begin
      word_next.x = up_word.x - dx;
      word_next.y = up_word.y + dy;
      word_next.z = up_word.z - ATAN_TURNS[STEP_IDX];
    end else begin
      word_next.x = up_word.x + dx;
      word_next.y = up_word.y - dy;
      word_next.z = up_word.z + ATAN_TURNS[STEP_IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word <= word_next;
    end
  end

endmodule

/* hw/rtl/epg_combine.sv */
// Rounds and unfolds cosine and sine, then forms point and tangent over three stages.
module epg_combine #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  epg_pkg::cordic_word_t              in_word,
  input  logic [epg_pkg::REG_W-1:0]          major_axis_vector,
  input  logic [epg_pkg::REG_W-1:0]          minor_axis_vector,
  input  logic [epg_pkg::REG_W-1:0]          center_vector,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [epg_pkg::OUT_W-1:0]   point [epg_pkg::AXES],
  output logic signed [epg_pkg::OUT_W-1:0]   tangent [epg_pkg::AXES]
);
  import epg_pkg::*;

  localparam int FRAC = COORD_BITS - 2;
  localparam int RSH  = 30 - FRAC;
  localparam int PW   = COORD_BITS + COMP_W;
  localparam int SW   = PW + 2;
  localparam logic signed [CORDIC_W:0] HALF_TRIG = (CORDIC_W+1)'(64'sd1 <<< (RSH - 1));
  localparam logic signed [SW-1:0]     HALF_OUT  = SW'(64'sd1 <<< (FRAC - 1));

  logic s1_valid, s2_valid;
  logic s1_ready, s2_ready, s3_ready;

  logic signed [CORDIC_W:0]   x_rnd, y_rnd;
  logic signed [COORD_BITS-1:0] c_val, s_val, cq_next, sq_next;
  logic signed [COORD_BITS-1:0] s1_cq, s1_sq;

  logic signed [PW-1:0]     s2_pu [AXES];
  logic signed [PW-1:0]     s2_pv [AXES];
  logic signed [PW-1:0]     s2_tu [AXES];
  logic signed [PW-1:0]     s2_tv [AXES];
  logic signed [COMP_W-1:0] s2_ctr [AXES];

  logic signed [SW-1:0]    pt_sum [AXES];
  logic signed [SW-1:0]    tg_sum [AXES];
  logic signed [OUT_W-1:0] point_next [AXES];
  logic signed [OUT_W-1:0] tangent_next [AXES];

  // Each stage takes a word when it is empty or its contents move on.
  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    x_rnd = (CORDIC_W+1)'(in_word.x) + HALF_TRIG;
    y_rnd = (CORDIC_W+1)'(in_word.y) + HALF_TRIG;
    c_val = $signed(x_rnd[RSH +: COORD_BITS]);
    s_val = $signed(y_rnd[RSH +: COORD_BITS]);
    unique case (in_word.quad)
      QUAD_FIRST: begin
        cq_next = c_val;
        sq_next = s_val;
      end
      QUAD_SECOND: begin
        cq_next = -s_val;
        sq_next = c_val;
      end
      QUAD_THIRD: begin
        cq_next = -c_val;
        sq_next = -s_val;
      end
      QUAD_FOURTH: begin
        cq_next = s_val;
        sq_next = -c_val;
      end
      default: begin
        cq_next = c_val;
        sq_next = s_val;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      pt_sum[k] = (SW'(s2_ctr[k]) <<< FRAC) + SW'(s2_pu[k]) + SW'(s2_pv[k]) + HALF_OUT;
      tg_sum[k] = SW'(s2_tv[k]) - SW'(s2_tu[k]) + HALF_OUT;
      point_next[k]   = $signed(pt_sum[k][FRAC +: OUT_W]);
      tangent_next[k] = $signed(tg_sum[k][FRAC +: OUT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_cq <= cq_next;
      s1_sq <= sq_next;
    end
    if (s1_valid && s2_ready) begin
      for (int k = 0; k < AXES; k++) begin
        s2_pu[k]  <= PW'(s1_cq) * PW'($signed(major_axis_vector[k*COMP_W +: COMP_W]));
        s2_pv[k]  <= PW'(s1_sq) * PW'($signed(minor_axis_vector[k*COMP_W +: COMP_W]));
        s2_tu[k]  <= PW'(s1_sq) * PW'($signed(major_axis_vector[k*COMP_W +: COMP_W]));
        s2_tv[k]  <= PW'(s1_cq) * PW'($signed(minor_axis_vector[k*COMP_W +: COMP_W]));
        s2_ctr[k] <= $signed(center_vector[k*COMP_W +: COMP_W]);
      end
    end
    if (s2_valid && s3_ready) begin
      for (int k = 0; k < AXES; k++) begin
        point[k]   <= point_next[k];
        tangent[k] <= tangent_next[k];
      end
    end
  end

endmodule

/* hw/rtl/epg_checker.sv */
// Port-level checks for the ellipse point generator and their binding to the top level.
module epg_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [epg_pkg::OUT_W-1:0] point_x,
  input logic signed [epg_pkg::OUT_W-1:0] point_y,
  input logic signed [epg_pkg::OUT_W-1:0] point_z,
  input logic signed [epg_pkg::OUT_W-1:0] tangent_x,
  input logic signed [epg_pkg::OUT_W-1:0] tangent_y,
  input logic signed [epg_pkg::OUT_W-1:0] tangent_z
);

  // Reset empties the pipeline, so no result word follows it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  // With the output stage empty every stage can move, so input must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(point_x) && $stable(point_y) && $stable(point_z)
      && $stable(tangent_x) && $stable(tangent_y) && $stable(tangent_z))
    else $error("result word changed while stalled");

endmodule

bind ellipse_point_generator_core epg_checker u_epg_checker (.*);
